/* rtl/tmd_pkg.sv */
package tmd_pkg;

  localparam int MAX_SIDE_DEF   = 256;
  localparam int MAX_RADIUS_DEF = 255;

  localparam logic [8:0]  GRID_W_RST    = 9'd64;
  localparam logic [8:0]  GRID_H_RST    = 9'd64;
  localparam logic [15:0] CELL_SIZE_RST = 16'd100;

  localparam logic [2:0] ZONE_FARMLAND = 3'd0;

  typedef enum logic [2:0] {
    ACT_FILL    = 3'd0,
    ACT_CLEAR   = 3'd1,
    ACT_PAINT   = 3'd2,
    ACT_QWORLD  = 3'd3,
    ACT_QGRID   = 3'd4
  } action_t;

  typedef enum logic [2:0] {
    REG_GRID_W   = 3'd0,
    REG_GRID_H   = 3'd1,
    REG_ORIGIN_X = 3'd2,
    REG_ORIGIN_Y = 3'd3,
    REG_CELL_SZ  = 3'd4,
    REG_DEF_ZONE = 3'd5
  } reg_idx_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_DIVX,
    ST_DIVY,
    ST_CHECK,
    ST_FILL,
    ST_PAINT_PT,
    ST_PAINT_WR,
    ST_READ,
    ST_READ_WAIT,
    ST_OUT
  } state_t;

  typedef struct packed {
    logic start;
    logic busy;
    logic done;
  } div_ctl_t;

endpackage

/* rtl/tmd_floor_div.sv */
// Serial floor division of a signed 33-bit dividend by an unsigned 16-bit
// divisor, one quotient bit a cycle on the magnitude, then a floor fix.
module tmd_floor_div
  import tmd_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  input  logic signed [32:0] dividend,
  input  logic [15:0]        divisor,
  output div_ctl_t           ctl,
  output logic signed [33:0] quotient
);

  logic [32:0] mag_r, mag_nxt;
  logic [32:0] quo_r, quo_nxt;
  logic [16:0] rem_r, rem_nxt;
  logic [15:0] dsr_r, dsr_nxt;
  logic        neg_r, neg_nxt;
  logic [5:0]  cnt_r, cnt_nxt;
  logic        busy_r, busy_nxt;
  logic        done_r, done_nxt;
  logic [17:0] trial;
  logic [16:0] shifted;

  always_comb begin
    mag_nxt  = mag_r;
    quo_nxt  = quo_r;
    rem_nxt  = rem_r;
    dsr_nxt  = dsr_r;
    neg_nxt  = neg_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    shifted  = {rem_r[15:0], mag_r[32]};
    trial    = {1'b0, shifted} - {2'b00, dsr_r};
    if (start) begin
      neg_nxt  = dividend[32];
      mag_nxt  = dividend[32] ? 33'(-dividend) : 33'(dividend);
      dsr_nxt  = (divisor == 16'd0) ? 16'd1 : divisor;
      rem_nxt  = '0;
      quo_nxt  = '0;
      cnt_nxt  = 6'd33;
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      mag_nxt = {mag_r[31:0], 1'b0};
      if (!trial[17]) begin
        rem_nxt = trial[16:0];
        quo_nxt = {quo_r[31:0], 1'b1};
      end else begin
        rem_nxt = shifted;
        quo_nxt = {quo_r[31:0], 1'b0};
      end
      cnt_nxt = cnt_r - 6'd1;
      if (cnt_r == 6'd1) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    mag_r <= mag_nxt;
    quo_r <= quo_nxt;
    rem_r <= rem_nxt;
    dsr_r <= dsr_nxt;
    neg_r <= neg_nxt;
    if (!rst_n) begin
      cnt_r  <= '0;
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      cnt_r  <= cnt_nxt;
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
  end

  // floor: negative with a remainder rounds one further down
  always_comb begin
    if (neg_r) begin
      quotient = -$signed({1'b0, quo_r}) - ((rem_r != '0) ? 34'sd1 : 34'sd0);
    end else begin
      quotient = $signed({1'b0, quo_r});
    end
  end

  assign ctl.start = start;
  assign ctl.busy  = busy_r;
  assign ctl.done  = done_r;

`ifndef SYNTHESIS
  a_done_after_busy: assert property (@(posedge clk) disable iff (!rst_n)
    done_r |-> $past(busy_r))
    else $error("divider done without busy");
  a_busy_count: assert property (@(posedge clk) disable iff (!rst_n)
    busy_r |-> cnt_r != 6'd0)
    else $error("divider busy with zero count");
  a_start_busy: assert property (@(posedge clk) disable iff (!rst_n)
    start |=> busy_r)
    else $error("divider did not start");
`endif

endmodule

/* rtl/tile_map_disc_paint_and_lookup.sv */
// Zone tile map: a MAX_SIDE x MAX_SIDE store of 3-bit zone codes with fill,
// clear, disc paint and two lookups. One item is taken at a time; in_tready
// is low while it is at work and while its result waits on the output.
// World queries and paint first run two serial floor divisions by cell_size
// on one shared 33-step divider. Fill writes one cell a cycle. Paint scans
// the (2r+1)^2 square around the centre, testing each point in ST_PAINT_PT
// and writing it in ST_PAINT_WR, writing the points that fall in the disc
// and on the map. The store needs no clearing pass: a fill count marks
// which entries are live.
module tile_map_disc_paint_and_lookup
  import tmd_pkg::*;
#(
  parameter int MAX_SIDE   = MAX_SIDE_DEF,
  parameter int MAX_RADIUS = MAX_RADIUS_DEF
) (
  input  logic         clk,
  input  logic         rst_n,
  // action[2:0], world_x[34:3], world_y[66:35], grid_x[82:67], grid_y[98:83],
  // brush_radius[106:99], zone[109:107], zero pad [111:110]
  input  logic         in_tvalid,
  output logic         in_tready,
  input  logic [111:0] in_tdata,
  // zone_out[2:0], cell_found[3], zone_matches[4], cells_written[21:5], pad
  output logic         out_tvalid,
  input  logic         out_tready,
  output logic [23:0]  out_tdata,
  input  logic         cfg_psel,
  input  logic         cfg_penable,
  input  logic         cfg_pwrite,
  input  logic [4:0]   cfg_paddr,
  input  logic [31:0]  cfg_pwdata,
  output logic [31:0]  cfg_prdata,
  output logic         cfg_pready
);

  localparam int SW    = $clog2(MAX_SIDE);
  localparam int AW    = 2 * SW;
  localparam int RW    = $clog2(MAX_RADIUS + 1);
  localparam int DEPTH = MAX_SIDE * MAX_SIDE;
  localparam int CW    = AW + 1;

  // configuration registers
  logic [8:0]  grid_w_r, grid_h_r;
  logic [31:0] origin_x_r, origin_y_r;
  logic [15:0] cell_size_r;
  logic [2:0]  def_zone_r;
  logic        cfg_wr;
  reg_idx_t    cfg_idx;

  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite;
  assign cfg_idx    = reg_idx_t'(cfg_paddr[4:2]);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      grid_w_r    <= GRID_W_RST;
      grid_h_r    <= GRID_H_RST;
      origin_x_r  <= '0;
      origin_y_r  <= '0;
      cell_size_r <= CELL_SIZE_RST;
      def_zone_r  <= ZONE_FARMLAND;
    end else if (cfg_wr) begin
      case (cfg_idx)
        REG_GRID_W:   grid_w_r    <= cfg_pwdata[8:0];
        REG_GRID_H:   grid_h_r    <= cfg_pwdata[8:0];
        REG_ORIGIN_X: origin_x_r  <= cfg_pwdata;
        REG_ORIGIN_Y: origin_y_r  <= cfg_pwdata;
        REG_CELL_SZ:  cell_size_r <= cfg_pwdata[15:0];
        REG_DEF_ZONE: def_zone_r  <= cfg_pwdata[2:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (cfg_idx)
      REG_GRID_W:   cfg_prdata = {23'd0, grid_w_r};
      REG_GRID_H:   cfg_prdata = {23'd0, grid_h_r};
      REG_ORIGIN_X: cfg_prdata = origin_x_r;
      REG_ORIGIN_Y: cfg_prdata = origin_y_r;
      REG_CELL_SZ:  cfg_prdata = {16'd0, cell_size_r};
      REG_DEF_ZONE: cfg_prdata = {29'd0, def_zone_r};
      default:      cfg_prdata = '0;
    endcase
  end

  // effective grid size, clamped to MAX_SIDE
  logic [SW:0] eff_w, eff_h;
  assign eff_w = ({23'd0, grid_w_r} > 32'(MAX_SIDE)) ? (SW+1)'(MAX_SIDE)
                                                      : (SW+1)'(grid_w_r);
  assign eff_h = ({23'd0, grid_h_r} > 32'(MAX_SIDE)) ? (SW+1)'(MAX_SIDE)
                                                      : (SW+1)'(grid_h_r);

  // item fields
  logic [2:0]  in_action;
  logic [31:0] in_wx, in_wy;
  logic [15:0] in_gx, in_gy;
  logic [7:0]  in_rad;
  logic [2:0]  in_zone;
  assign in_action = in_tdata[2:0];
  assign in_wx     = in_tdata[34:3];
  assign in_wy     = in_tdata[66:35];
  assign in_gx     = in_tdata[82:67];
  assign in_gy     = in_tdata[98:83];
  assign in_rad    = in_tdata[106:99];
  assign in_zone   = in_tdata[109:107];

  state_t state_r, state_nxt;
  logic [2:0]  act_r, act_nxt;
  logic [31:0] wy_r, wy_nxt;
  logic signed [33:0] px_r, px_nxt, py_r, py_nxt;
  logic [RW-1:0] rad_r, rad_nxt;
  logic [2:0]  zone_r, zone_nxt;
  logic signed [RW+1:0] ox_r, ox_nxt, oy_r, oy_nxt;
  logic [CW-1:0] filled_r, filled_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic [CW-1:0] idx_r, idx_nxt;
  logic [16:0] written_r, written_nxt;
  logic        hit_r, hit_nxt;
  logic [2:0]  res_zone_r, res_zone_nxt;
  logic        res_found_r, res_found_nxt;
  logic [2:0]  rd_zone_r;

  // divider
  logic               div_start;
  logic signed [32:0] div_dend;
  div_ctl_t           div_ctl;
  logic signed [33:0] div_q;

  tmd_floor_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (div_dend),
    .divisor  (cell_size_r),
    .ctl      (div_ctl),
    .quotient (div_q)
  );

  // cell existence test at point (tx,ty); one multiply, then compare
  logic signed [33:0] tx, ty;
  logic        t_in;
  logic [CW+SW:0] t_prod;
  logic [CW-1:0]  t_idx;
  logic           t_ok;
  always_comb begin
    t_in   = (tx >= 0) && (ty >= 0) && (tx < $signed(34'(eff_w)))
             && (ty < $signed(34'(eff_h)));
    t_prod = (CW+SW+1)'(ty[SW:0]) * (CW+SW+1)'(eff_w) + (CW+SW+1)'(tx[SW:0]);
    t_idx  = t_prod[CW-1:0];
    t_ok   = t_in && (t_prod < (CW+SW+1)'(filled_r));
  end

  // store
  logic [2:0]    mem [DEPTH];
  logic          mem_we;
  logic [AW-1:0] mem_wa, mem_ra;
  logic [2:0]    mem_wd;

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_wa] <= mem_wd;
    end
    rd_zone_r <= mem[mem_ra];
  end

  logic signed [2*RW+3:0] sq_sum;
  logic signed [2*RW+3:0] r_sq;
  assign sq_sum = (2*RW+4)'(ox_r * ox_r) + (2*RW+4)'(oy_r * oy_r);
  assign r_sq   = (2*RW+4)'($signed({2'b00, rad_r}) * $signed({2'b00, rad_r}));

  always_comb begin
    state_nxt     = state_r;
    act_nxt       = act_r;
    wy_nxt        = wy_r;
    px_nxt        = px_r;
    py_nxt        = py_r;
    rad_nxt       = rad_r;
    zone_nxt      = zone_r;
    ox_nxt        = ox_r;
    oy_nxt        = oy_r;
    filled_nxt    = filled_r;
    cnt_nxt       = cnt_r;
    idx_nxt       = idx_r;
    written_nxt   = written_r;
    hit_nxt       = hit_r;
    res_zone_nxt  = res_zone_r;
    res_found_nxt = res_found_r;
    div_start     = 1'b0;
    div_dend      = '0;
    mem_we        = 1'b0;
    mem_wa        = idx_r[AW-1:0];
    mem_wd        = zone_r;
    mem_ra        = idx_r[AW-1:0];
    tx            = px_r;
    ty            = py_r;
    in_tready     = 1'b0;
    out_tvalid    = 1'b0;
    case (state_r)
      ST_IDLE: begin
        in_tready = 1'b1;
        if (in_tvalid) begin
          act_nxt       = in_action;
          wy_nxt        = in_wy;
          rad_nxt       = (in_rad > 8'(MAX_RADIUS)) ? RW'(MAX_RADIUS) : RW'(in_rad);
          zone_nxt      = in_zone;
          written_nxt   = '0;
          res_zone_nxt  = ZONE_FARMLAND;
          res_found_nxt = 1'b0;
          px_nxt        = 34'($signed(in_gx));
          py_nxt        = 34'($signed(in_gy));
          case (action_t'(in_action))
            ACT_FILL: begin
              cnt_nxt    = CW'(eff_w * eff_h);
              filled_nxt = CW'(eff_w * eff_h);
              idx_nxt    = '0;
              written_nxt = 17'(eff_w * eff_h);
              state_nxt  = ST_FILL;
            end
            ACT_CLEAR: begin
              filled_nxt = '0;
              state_nxt  = ST_OUT;
            end
            ACT_PAINT, ACT_QWORLD: begin
              div_start = 1'b1;
              div_dend  = $signed({in_wx[31], in_wx}) - $signed({origin_x_r[31], origin_x_r});
              state_nxt = ST_DIVX;
            end
            ACT_QGRID: state_nxt = ST_CHECK;
            default:   state_nxt = ST_OUT;
          endcase
        end
      end
      ST_DIVX: begin
        if (div_ctl.done) begin
          px_nxt    = div_q;
          div_start = 1'b1;
          div_dend  = $signed({wy_r[31], wy_r}) - $signed({origin_y_r[31], origin_y_r});
          state_nxt = ST_DIVY;
        end
      end
      ST_DIVY: begin
        if (div_ctl.done) begin
          py_nxt    = div_q;
          state_nxt = ST_CHECK;
        end
      end
      ST_CHECK: begin
        // centre or query cell
        idx_nxt = t_idx;
        hit_nxt = t_ok;
        if (act_r == ACT_PAINT) begin
          ox_nxt    = -$signed({2'b00, rad_r});
          oy_nxt    = -$signed({2'b00, rad_r});
          state_nxt = t_ok ? ST_PAINT_PT : ST_OUT;
        end else begin
          state_nxt = t_ok ? ST_READ : ST_OUT;
        end
      end
      ST_FILL: begin
        if (cnt_r == '0) begin
          state_nxt = ST_OUT;
        end else begin
          mem_we  = 1'b1;
          mem_wd  = def_zone_r;
          idx_nxt = idx_r + CW'(1);
          cnt_nxt = cnt_r - CW'(1);
        end
      end
      ST_PAINT_PT: begin
        // test one point of the square; register the verdict and address
        tx      = px_r + 34'(ox_r);
        ty      = py_r + 34'(oy_r);
        idx_nxt = t_idx;
        hit_nxt = t_ok && (sq_sum <= r_sq);
        state_nxt = ST_PAINT_WR;
      end
      ST_PAINT_WR: begin
        if (hit_r) begin
          mem_we      = 1'b1;
          written_nxt = written_r + 17'd1;
        end
        if (ox_r == $signed({2'b00, rad_r})) begin
          ox_nxt = -$signed({2'b00, rad_r});
          if (oy_r == $signed({2'b00, rad_r})) begin
            state_nxt = ST_OUT;
          end else begin
            oy_nxt    = oy_r + (RW+2)'(1);
            state_nxt = ST_PAINT_PT;
          end
        end else begin
          ox_nxt    = ox_r + (RW+2)'(1);
          state_nxt = ST_PAINT_PT;
        end
      end
      ST_READ: state_nxt = ST_READ_WAIT;
      ST_READ_WAIT: begin
        res_zone_nxt  = rd_zone_r;
        res_found_nxt = 1'b1;
        state_nxt     = ST_OUT;
      end
      ST_OUT: begin
        out_tvalid = 1'b1;
        if (out_tready) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    act_r       <= act_nxt;
    wy_r        <= wy_nxt;
    px_r        <= px_nxt;
    py_r        <= py_nxt;
    rad_r       <= rad_nxt;
    zone_r      <= zone_nxt;
    ox_r        <= ox_nxt;
    oy_r        <= oy_nxt;
    cnt_r       <= cnt_nxt;
    idx_r       <= idx_nxt;
    written_r   <= written_nxt;
    hit_r       <= hit_nxt;
    res_zone_r  <= res_zone_nxt;
    res_found_r <= res_found_nxt;
    if (!rst_n) begin
      state_r  <= ST_IDLE;
      filled_r <= '0;
    end else begin
      state_r  <= state_nxt;
      filled_r <= filled_nxt;
    end
  end

  // result fields; query fields only count for the two lookups
  logic is_query, zone_match;
  assign is_query   = (act_r == ACT_QWORLD) || (act_r == ACT_QGRID);
  assign zone_match = is_query && (res_zone_r == zone_r);
  assign out_tdata  = {2'b00, written_r, zone_match, res_found_r, res_zone_r};

`ifndef SYNTHESIS
  a_ready_idle: assert property (@(posedge clk) disable iff (!rst_n)
    in_tready |-> !out_tvalid)
    else $error("input and output open together");
  a_found_query: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && res_found_r) |-> is_query)
    else $error("found flag on a non-query");
  a_write_busy: assert property (@(posedge clk) disable iff (!rst_n)
    mem_we |-> !in_tready)
    else $error("store written while idle");
`endif

endmodule

/* tb/tb.sv */
`timescale 1ns / 1ps

module tb;
  import tmd_pkg::*;

  // Action codes beyond the defined set: the block must answer them with an all-zero result
  localparam logic [2:0] ACT_SPARE5 = 3'd5;
  localparam logic [2:0] ACT_SPARE6 = 3'd6;
  localparam logic [2:0] ACT_SPARE7 = 3'd7;

  localparam logic [2:0] ZONE_FOREST     = 3'd1;
  localparam logic [2:0] ZONE_MOUNTAIN   = 3'd2;
  localparam logic [2:0] ZONE_WATER      = 3'd3;
  localparam logic [2:0] ZONE_SETTLEMENT = 3'd4;
  localparam logic [2:0] ZONE_PASTURE    = 3'd5;
  localparam logic [2:0] ZONE_UNDEF6     = 3'd6;
  localparam logic [2:0] ZONE_UNDEF7     = 3'd7;

  localparam int SIDE_LIMIT   = 256;
  localparam int RADIUS_LIMIT = 255;

  typedef struct {
    logic [2:0]  action;
    logic [31:0] wx;
    logic [31:0] wy;
    logic [15:0] gx;
    logic [15:0] gy;
    logic [7:0]  radius;
    logic [2:0]  zone;
  } map_cmd_t;

  typedef struct {
    logic [2:0]  zone_out;
    logic        found;
    logic        zone_match;
    logic [16:0] written;
  } map_answer_t;

  // Mirror of the tile map: keeps its own store, fill count and register copies,
  // and queues the answer each accepted command should produce.
  class zone_map_scoreboard;
    logic [2:0]   zones [SIDE_LIMIT*SIDE_LIMIT];
    int unsigned  filled;
    int unsigned  gw, gh, cs;
    longint       ox, oy;
    logic [2:0]   def_zone;
    map_answer_t  answers [$];
    int           errors;

    function new();
      filled   = 0;
      gw       = GRID_W_RST;
      gh       = GRID_H_RST;
      cs       = CELL_SIZE_RST;
      ox       = 0;
      oy       = 0;
      def_zone = ZONE_FARMLAND;
      errors   = 0;
    endfunction

    function void write_reg(reg_idx_t r, logic [31:0] v);
      case (r)
        REG_GRID_W:   gw = v[8:0];
        REG_GRID_H:   gh = v[8:0];
        REG_ORIGIN_X: ox = longint'(signed'(v));
        REG_ORIGIN_Y: oy = longint'(signed'(v));
        REG_CELL_SZ:  cs = v[15:0];
        REG_DEF_ZONE: def_zone = v[2:0];
        default: ;
      endcase
    endfunction

    function int unsigned width_eff();
      return (gw > SIDE_LIMIT) ? SIDE_LIMIT : gw;
    endfunction

    function int unsigned height_eff();
      return (gh > SIDE_LIMIT) ? SIDE_LIMIT : gh;
    endfunction

    // Floor division; a zero cell size behaves as one
    function longint cell_of(longint d);
      longint c;
      longint q;
      c = (cs == 0) ? 1 : cs;
      q = d / c;
      if ((d % c) != 0 && d < 0) q--;
      return q;
    endfunction

    function bit locate(longint x, longint y, output int unsigned idx);
      longint w;
      longint h;
      longint i;
      w = width_eff();
      h = height_eff();
      idx = 0;
      if (x < 0 || y < 0 || x >= w || y >= h) return 0;
      i = y * w + x;
      if (i >= filled) return 0;
      idx = 32'(i);
      return 1;
    endfunction

    function void note_input(map_cmd_t c);
      map_answer_t a;
      int unsigned idx;
      longint cx, cy, r;
      int unsigned n;
      a = '{default: '0};
      case (c.action)
        ACT_FILL: begin
          n = width_eff() * height_eff();
          for (int unsigned i = 0; i < n; i++) zones[i] = def_zone;
          filled = n;
          a.written = 17'(n);
        end
        ACT_CLEAR: filled = 0;
        ACT_PAINT: begin
          cx = cell_of(longint'(signed'(c.wx)) - ox);
          cy = cell_of(longint'(signed'(c.wy)) - oy);
          if (filled != 0 && locate(cx, cy, idx)) begin
            r = (c.radius > RADIUS_LIMIT) ? RADIUS_LIMIT : c.radius;
            for (longint dy = -r; dy <= r; dy++)
              for (longint dx = -r; dx <= r; dx++)
                if (dx*dx + dy*dy <= r*r && locate(cx + dx, cy + dy, idx)) begin
                  zones[idx] = c.zone;
                  a.written++;
                end
          end
        end
        ACT_QWORLD, ACT_QGRID: begin
          if (c.action == ACT_QWORLD) begin
            cx = cell_of(longint'(signed'(c.wx)) - ox);
            cy = cell_of(longint'(signed'(c.wy)) - oy);
          end else begin
            cx = longint'(signed'(c.gx));
            cy = longint'(signed'(c.gy));
          end
          if (locate(cx, cy, idx)) begin
            a.zone_out = zones[idx];
            a.found    = 1'b1;
          end
          a.zone_match = (a.zone_out == c.zone);
        end
        default: ;
      endcase
      answers.push_back(a);
    endfunction

    function void check(logic [23:0] d);
      map_answer_t e;
      if (answers.size() == 0) begin
        $error("result transfer with no command outstanding: %h", d);
        errors++;
        return;
      end
      e = answers.pop_front();
      if (d[2:0] !== e.zone_out) begin
        $error("zone_out expected %0d got %0d", e.zone_out, d[2:0]);
        errors++;
      end
      if (d[3] !== e.found) begin
        $error("cell_found expected %0d got %0d", e.found, d[3]);
        errors++;
      end
      if (d[4] !== e.zone_match) begin
        $error("zone_matches expected %0d got %0d", e.zone_match, d[4]);
        errors++;
      end
      if (d[21:5] !== e.written) begin
        $error("cells_written expected %0d got %0d", e.written, d[21:5]);
        errors++;
      end
    endfunction
  endclass

  logic         clk = 1'b0;
  logic         rst_n = 1'b0;
  logic         in_tvalid = 1'b0;
  logic         in_tready;
  logic [111:0] in_tdata = '0;
  logic         out_tvalid;
  logic         out_tready = 1'b0;
  logic [23:0]  out_tdata;
  logic         cfg_psel = 1'b0;
  logic         cfg_penable = 1'b0;
  logic         cfg_pwrite = 1'b0;
  logic [4:0]   cfg_paddr = '0;
  logic [31:0]  cfg_pwdata = '0;
  logic [31:0]  cfg_prdata;
  logic         cfg_pready;

  zone_map_scoreboard map_sb = new();
  int hold_off_cycles = 0;

  always #2 clk = ~clk;

  tile_map_disc_paint_and_lookup i_dut (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .cfg_psel(cfg_psel), .cfg_penable(cfg_penable), .cfg_pwrite(cfg_pwrite),
    .cfg_paddr(cfg_paddr), .cfg_pwdata(cfg_pwdata), .cfg_prdata(cfg_prdata),
    .cfg_pready(cfg_pready)
  );

  // Short gaps mostly, with the odd long one
  function automatic int pick_gap();
    int p;
    p = $urandom_range(99);
    if (p < 45) return 0;
    if (p < 90) return $urandom_range(3, 1);
    return $urandom_range(40, 10);
  endfunction

  // Receiver: a requested hold-off takes priority, otherwise stall at random
  initial begin
    int stall;
    stall = 0;
    forever begin
      @(posedge clk);
      if (hold_off_cycles > 0) begin
        out_tready <= 1'b0;
        hold_off_cycles--;
      end else if (stall > 0) begin
        out_tready <= 1'b0;
        stall--;
      end else begin
        out_tready <= 1'b1;
        if ($urandom_range(9) < 3) stall = pick_gap();
      end
    end
  end

  // Check each result transfer against the oldest outstanding answer
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) map_sb.check(out_tdata);
  end

  // Present one command; valid stays high afterwards so a back-to-back command
  // follows without a bubble. The expectation is queued at the accepting edge.
  task automatic send_cmd(map_cmd_t c);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {2'b00, c.zone, c.radius, c.gy, c.gx, c.wy, c.wx, c.action};
    do @(posedge clk); while (!in_tready);
    map_sb.note_input(c);
  endtask

  // Drop valid and hold off until every result has come back
  task automatic drain();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (map_sb.answers.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
  endtask

  task automatic write_reg(reg_idx_t r, logic [31:0] v);
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b1;
    cfg_paddr   <= 5'(r) << 2;
    cfg_pwdata  <= v;
    @(posedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
    map_sb.write_reg(r, v);
  endtask

  task automatic set_map(int w, int h, logic [31:0] ox, logic [31:0] oy, int cs, logic [2:0] dz);
    write_reg(REG_GRID_W, w);
    write_reg(REG_GRID_H, h);
    write_reg(REG_ORIGIN_X, ox);
    write_reg(REG_ORIGIN_Y, oy);
    write_reg(REG_CELL_SZ, cs);
    write_reg(REG_DEF_ZONE, dz);
  endtask

  function automatic map_cmd_t mk(logic [2:0] act, logic [31:0] wx = '0, logic [31:0] wy = '0,
                                  logic [15:0] gx = '0, logic [15:0] gy = '0,
                                  logic [7:0] r = '0, logic [2:0] z = '0);
    map_cmd_t c;
    c = '{act, wx, wy, gx, gy, r, z};
    return c;
  endfunction

  // World coordinate aimed at a cell near the map, somewhere inside that cell
  function automatic logic [31:0] aim(longint org, int unsigned side);
    longint c;
    longint k;
    c = (map_sb.cs == 0) ? 1 : map_sb.cs;
    k = longint'($urandom_range(side + 3)) - 2;
    return 32'(org + k * c + longint'($urandom_range(32'(c - 1))));
  endfunction

  function automatic map_cmd_t rand_cmd(int max_r);
    map_cmd_t c;
    int p;
    int unsigned w, h;
    w = map_sb.width_eff();
    h = map_sb.height_eff();
    c.zone = 3'($urandom_range(7));
    c.radius = ($urandom_range(19) == 0) ? 8'($urandom_range(255) % (max_r + 1))
                                         : 8'($urandom_range(max_r < 5 ? max_r : 5));
    if ($urandom_range(9) == 0) begin
      c.wx = $urandom;
      c.wy = $urandom;
    end else begin
      c.wx = aim(map_sb.ox, w);
      c.wy = aim(map_sb.oy, h);
    end
    if ($urandom_range(9) == 0) begin
      c.gx = 16'($urandom);
      c.gy = 16'($urandom);
    end else begin
      c.gx = 16'(int'($urandom_range(w + 2)) - 1);
      c.gy = 16'(int'($urandom_range(h + 2)) - 1);
    end
    p = $urandom_range(99);
    if      (p < 6)  c.action = ACT_FILL;
    else if (p < 9)  c.action = ACT_CLEAR;
    else if (p < 36) c.action = ACT_PAINT;
    else if (p < 66) c.action = ACT_QWORLD;
    else if (p < 95) c.action = ACT_QGRID;
    else             c.action = 3'($urandom_range(7, 5));
    return c;
  endfunction

  initial begin
    int w, h;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Reset map (64 x 64, cell 100): empty map, fill, lookups at the edges
    send_cmd(mk(ACT_QGRID, , , 16'd0, 16'd0, , ZONE_FARMLAND));
    send_cmd(mk(ACT_PAINT, 32'd50, 32'd50, , , 8'd3, ZONE_WATER));
    send_cmd(mk(ACT_FILL));
    send_cmd(mk(ACT_PAINT, 32'd50, 32'd50, , , 8'd3, ZONE_WATER));
    send_cmd(mk(ACT_PAINT, 32'd6399, 32'd6399, , , 8'd0, ZONE_FOREST));
    send_cmd(mk(ACT_PAINT, 32'd6400, 32'd100, , , 8'd4, ZONE_MOUNTAIN));
    send_cmd(mk(ACT_PAINT, 32'hFFFF_FFFF, 32'd100, , , 8'd4, ZONE_MOUNTAIN));
    send_cmd(mk(ACT_PAINT, 32'd3200, 32'd3200, , , 8'd2, ZONE_UNDEF7));
    send_cmd(mk(ACT_QGRID, , , 16'd32, 16'd32, , ZONE_UNDEF7));
    send_cmd(mk(ACT_QGRID, , , 16'd63, 16'd63, , ZONE_FOREST));
    send_cmd(mk(ACT_QGRID, , , 16'h8000, 16'h7FFF, , ZONE_FARMLAND));
    send_cmd(mk(ACT_QGRID, , , 16'h7FFF, 16'h8000, , ZONE_FARMLAND));
    send_cmd(mk(ACT_QGRID, , , 16'd64, 16'd0, , ZONE_FARMLAND));
    send_cmd(mk(ACT_QWORLD, 32'd0, 32'd199, , , , ZONE_WATER));
    send_cmd(mk(ACT_QWORLD, 32'h8000_0000, 32'h7FFF_FFFF, , , , ZONE_FARMLAND));
    send_cmd(mk(ACT_QWORLD, 32'hFFFF_FF9C, 32'd0, , , , ZONE_FARMLAND));
    send_cmd(mk(ACT_SPARE5, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 16'hFFFF, 16'hFFFF, 8'hFF, ZONE_UNDEF7));
    send_cmd(mk(ACT_SPARE6));
    send_cmd(mk(ACT_SPARE7, , , , , , ZONE_PASTURE));
    // Widest brush: the disc covers the whole map
    send_cmd(mk(ACT_PAINT, 32'd3200, 32'd3200, , , 8'd255, ZONE_SETTLEMENT));
    send_cmd(mk(ACT_QGRID, , , 16'd0, 16'd63, , ZONE_SETTLEMENT));
    send_cmd(mk(ACT_CLEAR));
    send_cmd(mk(ACT_QGRID, , , 16'd1, 16'd1, , ZONE_FARMLAND));
    send_cmd(mk(ACT_PAINT, 32'd150, 32'd150, , , 8'd1, ZONE_PASTURE));
    drain();

    // Oversized width acts as the maximum side; extreme origins, largest cell
    set_map(9'h1FF, 256, 32'h8000_0000, 32'h7FFF_0000, 65535, ZONE_UNDEF7);
    send_cmd(mk(ACT_FILL));
    send_cmd(mk(ACT_QWORLD, 32'h8000_0000, 32'h7FFF_0000, , , , ZONE_UNDEF7));
    send_cmd(mk(ACT_QWORLD, 32'h7FFF_FFFF, 32'h7FFF_FFFF, , , , ZONE_UNDEF7));
    send_cmd(mk(ACT_PAINT, 32'h8000_FFFF, 32'h7FFF_FFFF, , , 8'd2, ZONE_UNDEF6));
    send_cmd(mk(ACT_QGRID, , , 16'd255, 16'd255, , ZONE_UNDEF7));
    send_cmd(mk(ACT_QGRID, , , 16'd1, 16'd0, , ZONE_UNDEF6));
    drain();

    // Zero width gives an empty map; zero cell size acts as one
    set_map(0, 5, 32'hFFFF_FFF0, 32'd16, 0, ZONE_WATER);
    send_cmd(mk(ACT_FILL));
    send_cmd(mk(ACT_QGRID, , , 16'd0, 16'd0, , ZONE_FARMLAND));
    drain();
    write_reg(REG_GRID_W, 7);
    send_cmd(mk(ACT_FILL));
    send_cmd(mk(ACT_QWORLD, 32'hFFFF_FFF6, 32'd20, , , , ZONE_WATER));
    send_cmd(mk(ACT_PAINT, 32'hFFFF_FFF3, 32'd18, , , 8'd1, ZONE_FOREST));
    send_cmd(mk(ACT_QGRID, , , 16'd3, 16'd3, , ZONE_FOREST));
    drain();

    // Random phases over small maps; the fill count is kept across some
    // resizes so that stale indexing against the new registers is covered
    for (int ph = 0; ph < 6; ph++) begin
      w = $urandom_range(20, 1);
      h = $urandom_range(20, 1);
      write_reg(REG_GRID_W, w);
      write_reg(REG_GRID_H, h);
      write_reg(REG_ORIGIN_X, $urandom);
      write_reg(REG_ORIGIN_Y, $urandom);
      case ($urandom_range(3))
        0: write_reg(REG_CELL_SZ, 1);
        1: write_reg(REG_CELL_SZ, 65535);
        default: write_reg(REG_CELL_SZ, $urandom_range(1000, 0));
      endcase
      write_reg(REG_DEF_ZONE, $urandom_range(7));
      if (ph == 2) hold_off_cycles = 400;
      if (ph != 3) send_cmd(mk(ACT_FILL));
      repeat (70) send_cmd(rand_cmd(ph == 5 ? 40 : 8));
      drain();
    end

    repeat (50) @(posedge clk);
    if (map_sb.errors == 0 && map_sb.answers.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

  // Watchdog: far beyond the slowest legal run
  initial begin
    #20_000_000;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule

/* sim.f */
rtl/tmd_pkg.sv
rtl/tmd_floor_div.sv
rtl/tile_map_disc_paint_and_lookup.sv
tb/tb.sv
